>>> rtl/uktab_pkg.sv
// Package with the shared types and constants of the unique-key compacting table.
`timescale 1ns / 1ps
`default_nettype none

package uktab_pkg;

  // Built table depth used as the default of the top-level parameter.
  localparam int unsigned DefaultDepth = 64;

  // Fixed widths of the transaction fields.
  localparam int unsigned KeyW    = 32;
  localparam int unsigned AmountW = 16;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned SumW    = 22;
  localparam int unsigned CapW    = 7;

  // Configuration port.
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam logic [ApbAddrW-1:0] RegCapacity = 3'd0;
  localparam logic [CapW-1:0] CapacityReset = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_DEL_KEY = 2'd1,
    OP_DEL_IDX = 2'd2,
    OP_FIND    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_LOAD,
    S_SHIFT,
    S_DONE
  } state_e;

  // One table entry as it is stored in the memory.
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [AmountW-1:0] amount;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

`default_nettype wire

>>> rtl/uktab_if.sv
// Handshake interfaces for the request and response channels of the table.
`timescale 1ns / 1ps
`default_nettype none

interface uktab_req_if;
  logic                                 valid;
  logic                                 ready;
  uktab_pkg::op_e                       opcode;
  logic [uktab_pkg::KeyW-1:0]           key;
  logic [uktab_pkg::AmountW-1:0]        amount;
  logic [uktab_pkg::IndexW-1:0]         entry_index;

  modport source (output valid, output opcode, output key, output amount,
                  output entry_index, input ready);
  modport sink   (input valid, input opcode, input key, input amount,
                  input entry_index, output ready);
endinterface

interface uktab_rsp_if;
  logic                                 valid;
  logic                                 ready;
  uktab_pkg::status_e                   status;
  logic [uktab_pkg::AmountW-1:0]        found_amount;
  logic [uktab_pkg::IndexW-1:0]         found_index;
  logic [uktab_pkg::CountW-1:0]         entry_count;
  logic [uktab_pkg::SumW-1:0]           total_amount;

  modport source (output valid, output status, output found_amount,
                  output found_index, output entry_count, output total_amount,
                  input ready);
  modport sink   (input valid, input status, input found_amount,
                  input found_index, input entry_count, input total_amount,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/uktab_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module uktab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/unique_key_compacting_table.sv
// Top level of the unique-key compacting table: control sequencer, registers and entry memory.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake         Payload
// req_i      in   valid / ready     opcode, key, amount, entry_index
// rsp_o      out  valid / ready     status, found_amount, found_index, entry_count,
//                                   total_amount
// APB        in   psel / penable    paddr, pwdata, prdata (capacity at byte address 0)
//
// One transaction is handled at a time; a key search reads one entry per cycle. Add and find
// search the held entries; delete by key searches and then moves the entries above the hit
// down one place, and delete by index reads the removed entry and moves those above it down.
// Reset clears the count and the total and sets the capacity to 64; the entry memory is not
// cleared, since only positions below the count are ever read. A result waits in the output
// register while the next request is accepted; the sequencer stalls only in its final state.

module unique_key_compacting_table #(
  parameter int unsigned DEPTH = uktab_pkg::DefaultDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  uktab_req_if.sink                            req_i,
  uktab_rsp_if.source                          rsp_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [uktab_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [uktab_pkg::ApbDataW-1:0]  pwdata,
  output      logic [uktab_pkg::ApbDataW-1:0]  prdata,
  output      logic                            pready
);

  // Address width of the entry memory and width of counts that can reach DEPTH.
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Configuration register.
  logic [uktab_pkg::CapW-1:0] capacity_q, capacity_d;
  logic                       cfg_write;
  logic                       cap_sel;

  // Sequencer state.
  uktab_pkg::state_e state_q, state_d;

  // Latched request.
  uktab_pkg::op_e                 op_q, op_d;
  logic [uktab_pkg::KeyW-1:0]     key_q, key_d;
  logic [uktab_pkg::AmountW-1:0]  amt_q, amt_d;
  logic [uktab_pkg::IndexW-1:0]   idx_q, idx_d;

  // Table state held in registers.
  logic [CW-1:0]                  fill_q, fill_d;
  logic [uktab_pkg::SumW-1:0]     sum_q, sum_d;

  // Scan pointer: scan_q is the next address to read, pidx_q the address whose
  // data is on the memory output when pend_q is set.
  logic [CW-1:0] scan_q, scan_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          pend_q, pend_d;

  // Result staging and output register.
  uktab_pkg::status_e             res_status_q, res_status_d;
  logic [uktab_pkg::AmountW-1:0]  res_famt_q, res_famt_d;
  logic [uktab_pkg::IndexW-1:0]   res_fidx_q, res_fidx_d;

  logic                           out_valid_q, out_valid_d;
  uktab_pkg::status_e             out_status_q, out_status_d;
  logic [uktab_pkg::AmountW-1:0]  out_famt_q, out_famt_d;
  logic [uktab_pkg::IndexW-1:0]   out_fidx_q, out_fidx_d;
  logic [uktab_pkg::CountW-1:0]   out_count_q, out_count_d;
  logic [uktab_pkg::SumW-1:0]     out_sum_q, out_sum_d;

  // Memory ports.
  logic                           ram_we, ram_re;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  uktab_pkg::entry_t              ram_wdata, rd_entry;
  logic [uktab_pkg::EntryW-1:0]   ram_rdata;

  // Decoded conditions.
  logic req_acc;
  logic full;
  logic idx_ok;
  logic hit;
  logic scan_end;
  logic slot_free;

  // ---------------------------------------------------------------------------
  // Configuration port. Only the capacity register exists; other word
  // addresses read as zero and ignore writes.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cap_sel   = (paddr[uktab_pkg::ApbAddrW-1:2] ==
                      uktab_pkg::RegCapacity[uktab_pkg::ApbAddrW-1:2]);

  always_comb begin
    capacity_d = capacity_q;
    if (cfg_write && cap_sel) begin
      capacity_d = pwdata[uktab_pkg::CapW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cap_sel) begin
      prdata = uktab_pkg::ApbDataW'(capacity_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Conditions.
  // ---------------------------------------------------------------------------
  assign req_i.ready = (state_q == uktab_pkg::S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // The usable limit is the smaller of the capacity register and the built depth.
  assign full   = (32'(fill_q) >= 32'(capacity_q)) || (32'(fill_q) >= 32'(DEPTH));
  assign idx_ok = 32'(req_i.entry_index) < 32'(fill_q);

  assign rd_entry  = uktab_pkg::entry_t'(ram_rdata);
  assign hit       = pend_q && (rd_entry.key == key_q);
  assign scan_end  = !pend_q && (scan_q >= fill_q);
  assign slot_free = !out_valid_q || rsp_o.ready;

  // ---------------------------------------------------------------------------
  // Next-state logic.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      uktab_pkg::S_IDLE: begin
        if (req_acc) begin
          case (req_i.opcode)
            uktab_pkg::OP_ADD:     state_d = full ? uktab_pkg::S_DONE : uktab_pkg::S_SEARCH;
            uktab_pkg::OP_DEL_IDX: state_d = idx_ok ? uktab_pkg::S_FETCH : uktab_pkg::S_DONE;
            default:               state_d = uktab_pkg::S_SEARCH;
          endcase
        end
      end
      uktab_pkg::S_SEARCH: begin
        if (hit) begin
          state_d = (op_q == uktab_pkg::OP_DEL_KEY) ? uktab_pkg::S_SHIFT : uktab_pkg::S_DONE;
        end else if (scan_end) begin
          state_d = uktab_pkg::S_DONE;
        end
      end
      uktab_pkg::S_FETCH: state_d = uktab_pkg::S_LOAD;
      uktab_pkg::S_LOAD:  state_d = uktab_pkg::S_SHIFT;
      uktab_pkg::S_SHIFT: begin
        if (scan_end) begin
          state_d = uktab_pkg::S_DONE;
        end
      end
      uktab_pkg::S_DONE: begin
        if (slot_free) begin
          state_d = uktab_pkg::S_IDLE;
        end
      end
      default: state_d = uktab_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control.
  // ---------------------------------------------------------------------------
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    amt_d        = amt_q;
    idx_d        = idx_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    scan_d       = scan_q;
    pidx_d       = pidx_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_famt_d   = res_famt_q;
    res_fidx_d   = res_fidx_q;
    out_status_d = out_status_q;
    out_famt_d   = out_famt_q;
    out_fidx_d   = out_fidx_q;
    out_count_d  = out_count_q;
    out_sum_d    = out_sum_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_q)
      uktab_pkg::S_IDLE: begin
        if (req_acc) begin
          op_d         = req_i.opcode;
          key_d        = req_i.key;
          amt_d        = req_i.amount;
          idx_d        = req_i.entry_index;
          scan_d       = '0;
          pend_d       = 1'b0;
          res_famt_d   = '0;
          res_fidx_d   = '0;
          res_status_d = uktab_pkg::ST_OK;
          if ((req_i.opcode == uktab_pkg::OP_ADD) && full) begin
            res_status_d = uktab_pkg::ST_FULL;
          end else if ((req_i.opcode == uktab_pkg::OP_DEL_IDX) && !idx_ok) begin
            res_status_d = uktab_pkg::ST_MISS;
          end
        end
      end

      uktab_pkg::S_SEARCH: begin
        if (hit) begin
          pend_d = 1'b0;
          case (op_q)
            uktab_pkg::OP_ADD: res_status_d = uktab_pkg::ST_DUP;
            uktab_pkg::OP_FIND: begin
              res_famt_d = rd_entry.amount;
              res_fidx_d = uktab_pkg::IndexW'(pidx_q);
            end
            uktab_pkg::OP_DEL_KEY: begin
              sum_d  = sum_q - uktab_pkg::SumW'(rd_entry.amount);
              scan_d = CW'(pidx_q) + CW'(1);
            end
            default: ;
          endcase
        end else if (scan_end) begin
          if (op_q == uktab_pkg::OP_ADD) begin
            ram_we           = 1'b1;
            ram_waddr        = fill_q[AW-1:0];
            ram_wdata.key    = key_q;
            ram_wdata.amount = amt_q;
            fill_d           = fill_q + CW'(1);
            sum_d            = sum_q + uktab_pkg::SumW'(amt_q);
          end else begin
            res_status_d = uktab_pkg::ST_MISS;
          end
        end else if (scan_q < fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = scan_q[AW-1:0];
          pidx_d    = scan_q[AW-1:0];
          pend_d    = 1'b1;
          scan_d    = scan_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end

      uktab_pkg::S_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(idx_q);
      end

      uktab_pkg::S_LOAD: begin
        sum_d  = sum_q - uktab_pkg::SumW'(rd_entry.amount);
        scan_d = CW'(idx_q) + CW'(1);
        pend_d = 1'b0;
      end

      uktab_pkg::S_SHIFT: begin
        // Entry read last cycle moves one place down.
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q - AW'(1);
          ram_wdata = rd_entry;
        end
        if (scan_end) begin
          fill_d = fill_q - CW'(1);
        end else if (scan_q < fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = scan_q[AW-1:0];
          pidx_d    = scan_q[AW-1:0];
          pend_d    = 1'b1;
          scan_d    = scan_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end

      uktab_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_famt_d   = res_famt_q;
          out_fidx_d   = res_fidx_q;
          out_count_d  = uktab_pkg::CountW'(fill_q);
          out_sum_d    = sum_q;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uktab_pkg::S_IDLE;
      capacity_q  <= uktab_pkg::CapacityReset;
      fill_q      <= '0;
      sum_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      capacity_q  <= capacity_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    amt_q        <= amt_d;
    idx_q        <= idx_d;
    scan_q       <= scan_d;
    pidx_q       <= pidx_d;
    res_status_q <= res_status_d;
    res_famt_q   <= res_famt_d;
    res_fidx_q   <= res_fidx_d;
    out_status_q <= out_status_d;
    out_famt_q   <= out_famt_d;
    out_fidx_q   <= out_fidx_d;
    out_count_q  <= out_count_d;
    out_sum_q    <= out_sum_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.found_amount = out_famt_q;
  assign rsp_o.found_index  = out_fidx_q;
  assign rsp_o.entry_count  = out_count_q;
  assign rsp_o.total_amount = out_sum_q;

  // ---------------------------------------------------------------------------
  // Entry memory: key and amount side by side in one word.
  // ---------------------------------------------------------------------------
  uktab_ram #(
    .Width (uktab_pkg::EntryW),
    .Depth (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  // The entry count never passes the built depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(DEPTH))
    else $error("entry count beyond table depth");

  // A compaction step never reads the entry it is writing in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write to the same entry in one cycle");

  // Data compared during a search always comes from a held entry.
  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == uktab_pkg::S_SEARCH) && pend_q) |-> (CW'(pidx_q) < fill_q))
    else $error("search compared an entry beyond the count");

  // A new result only appears after the sequencer reached its final state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && !rsp_o.ready)) |->
      $past(state_q == uktab_pkg::S_DONE))
    else $error("result issued outside the final state");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the unique-key compacting table: stimulus, scoreboard and checks.
`timescale 1ns / 1ps

// The testbench drives request transactions into the table and checks every response
// transaction against a scoreboard. The scoreboard keeps its own copy of the table and
// works out the expected result when a request is accepted.
//
// The stimulus starts with a short directed sequence. It covers:
//   - an empty table,
//   - the extreme keys, amounts and positions,
//   - duplicate keys and missing keys,
//   - bad positions,
//   - a full table, where the full check wins over the duplicate check,
//   - a capacity lowered below the number of held entries,
//   - a capacity of zero,
//   - a write to an unmapped register address.
// Random phases follow, each setting a capacity and a mix of operations. Some
// phases fill the table and others drain it, so the search and the compaction walk run
// over the whole depth. Delete and find requests mostly target keys that are held, so
// that they hit. A share of the requests carries random keys and positions, so that the
// error paths are also taken.
//
// Both sides of the handshake idle in short random bursts. Once during the run, the
// result side holds off for a long stretch, so the block fills up and stalls its input.
// The last phase runs with no idling at all.
module testbench;
  import uktab_pkg::*;

  localparam int unsigned TableDepth     = DefaultDepth;
  localparam int unsigned PhaseCount     = 7;
  localparam int unsigned ItemsPerPhase  = 133;
  // One full search or compaction walk, with margin, before the run is closed.
  localparam int unsigned DrainCycles    = 2 * TableDepth + 16;
  // Covers the long hold-off plus the slowest transaction and the longest idle bursts.
  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned LongHoldAfter  = 300;
  localparam int unsigned MaxPrinted     = 40;
  // Byte address of register index 1, which does not exist and must be ignored.
  localparam logic [ApbAddrW-1:0] UnmappedAddr = 3'd4;

  // One response transaction, field by field.
  typedef struct packed {
    status_e            status;
    logic [AmountW-1:0] found_amount;
    logic [IndexW-1:0]  found_index;
    logic [CountW-1:0]  entry_count;
    logic [SumW-1:0]    total_amount;
  } table_result_t;

  // The scoreboard mirrors the table contents, the count, the running total and the
  // capacity. It queues one expected result for each accepted request.
  class compaction_scoreboard;
    logic [KeyW-1:0]    held_keys    [TableDepth];
    logic [AmountW-1:0] held_amounts [TableDepth];
    int unsigned        fill;
    int unsigned        peak_fill;
    logic [SumW-1:0]    amount_total;
    logic [CapW-1:0]    capacity;
    table_result_t      awaited_results [$];
    int unsigned        op_count [4];
    int unsigned        status_count [4];
    int unsigned        results_checked;
    int unsigned        mismatches;

    function new();
      amount_total = '0;
      capacity     = CapacityReset;
    endfunction

    // Position of a held key, or the fill level when the key is absent.
    function int unsigned locate(logic [KeyW-1:0] key);
      for (int unsigned i = 0; i < fill; i++) begin
        if (held_keys[i] == key) return i;
      end
      return fill;
    endfunction

    function void remove_entry(int unsigned pos);
      amount_total = amount_total - held_amounts[pos];
      fill--;
      for (int unsigned i = pos; i < fill; i++) begin
        held_keys[i]    = held_keys[i + 1];
        held_amounts[i] = held_amounts[i + 1];
      end
    endfunction

    // Applies an accepted request to the mirror and queues the result it must produce.
    function void note_request(op_e op, logic [KeyW-1:0] key, logic [AmountW-1:0] amount,
                               logic [IndexW-1:0] slot);
      table_result_t want;
      int unsigned   limit;
      int unsigned   pos;
      want  = '{status: ST_OK, default: '0};
      limit = (capacity < TableDepth) ? capacity : TableDepth;
      pos   = locate(key);
      case (op)
        OP_ADD: begin
          // The full check comes before the duplicate check.
          if (fill >= limit) begin
            want.status = ST_FULL;
          end else if (pos < fill) begin
            want.status = ST_DUP;
          end else begin
            held_keys[fill]    = key;
            held_amounts[fill] = amount;
            fill++;
            amount_total = amount_total + amount;
          end
        end
        OP_DEL_KEY: begin
          if (pos < fill) remove_entry(pos);
          else want.status = ST_MISS;
        end
        OP_DEL_IDX: begin
          if (slot < fill) remove_entry(slot);
          else want.status = ST_MISS;
        end
        default: begin
          if (pos < fill) begin
            want.found_amount = held_amounts[pos];
            want.found_index  = IndexW'(pos);
          end else begin
            want.status = ST_MISS;
          end
        end
      endcase
      want.entry_count  = CountW'(fill);
      want.total_amount = amount_total;
      if (fill > peak_fill) peak_fill = fill;
      op_count[op]++;
      status_count[want.status]++;
      awaited_results.push_back(want);
    endfunction

    task check_result(table_result_t got);
      table_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with status %0d arrived with no request outstanding",
                                  got.status));
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      check_field("status", got.status, want.status);
      check_field("found_amount", got.found_amount, want.found_amount);
      check_field("found_index", got.found_index, want.found_index);
      check_field("entry_count", got.entry_count, want.entry_count);
      check_field("total_amount", got.total_amount, want.total_amount);
    endtask

    task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v) begin
        report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                  results_checked, name, got_v, want_v));
      end
    endtask

    // Every mismatch is counted. Only the first few are printed, to keep the log short.
    task report_mismatch(string what);
      if (mismatches < MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask
  endclass

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  uktab_req_if req_if ();
  uktab_rsp_if rsp_if ();

  compaction_scoreboard sb;
  logic [KeyW-1:0]      key_pool [8];
  int unsigned          results_accepted;
  int unsigned          capacity_settings;
  int unsigned          idle_cycles;
  bit                   quiet_tail;

  unique_key_compacting_table DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // Both channels are sampled at the rising edge, before any update that the edge causes.
  // The request is noted first, in case a result ever comes in the cycle of its request.
  // The same block runs the watchdog. It counts the cycles in which neither channel
  // moves a transaction.
  always @(posedge clk_i) begin : channel_monitor
    table_result_t got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.opcode, req_if.key, req_if.amount, req_if.entry_index);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.status       = rsp_if.status;
        got.found_amount = rsp_if.found_amount;
        got.found_index  = rsp_if.found_index;
        got.entry_count  = rsp_if.entry_count;
        got.total_amount = rsp_if.total_amount;
        sb.check_result(got);
        results_accepted++;
      end
    end
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d results still awaited",
                 idle_cycles, sb.awaited_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // The result side idles in short random bursts. Once, it holds off for a long
  // stretch while the request side keeps offering transactions.
  initial begin : result_sink
    int unsigned pause;
    bit          long_hold_done;
    pause          = 0;
    long_hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pause != 0) begin
        pause--;
      end else if (!long_hold_done && results_accepted >= LongHoldAfter) begin
        long_hold_done = 1'b1;
        pause          = LongHoldCycles - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < 12) begin
        pause = $urandom_range(0, 5);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offers one request and holds it until it is accepted. Sometimes the request side
  // then idles for a short burst.
  task automatic issue(op_e op, logic [KeyW-1:0] key, logic [AmountW-1:0] amount,
                       logic [IndexW-1:0] slot);
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.key         <= key;
    req_if.amount      <= amount;
    req_if.entry_index <= slot;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (!quiet_tail && $urandom_range(0, 99) < 20) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Waits until the block has returned every expected result. Every request produces
  // a result, so the block is idle once the scoreboard queue is empty.
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.awaited_results.size() != 0);
  endtask

  // Reads back the capacity register and compares it with the mirrored value.
  task automatic check_capacity();
    logic [ApbDataW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RegCapacity;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (readback[CapW-1:0] !== sb.capacity) begin
      sb.report_mismatch($sformatf("capacity reads back 0x%0h, expected 0x%0h",
                                   readback[CapW-1:0], sb.capacity));
    end
  endtask

  // Writes a register while the block is idle and then reads the capacity back. The
  // upper data bits are random, because the register takes only its low bits.
  task automatic configure(logic [ApbAddrW-1:0] addr, logic [CapW-1:0] cap);
    logic [ApbDataW-1:0] data;
    data           = $urandom();
    data[CapW-1:0] = cap;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (addr == RegCapacity) begin
      sb.capacity = cap;
      capacity_settings++;
    end
    check_capacity();
  endtask

  // Random request. Deletes and finds mostly target held keys and valid positions, so
  // that they reach deep into the table. Adds sometimes reuse a held key to provoke a
  // duplicate. The rest of the keys come from a small pool or are fully random.
  task automatic random_request(int unsigned add_pct);
    op_e                op;
    logic [KeyW-1:0]    key;
    logic [AmountW-1:0] amount;
    logic [IndexW-1:0]  slot;
    int unsigned        roll;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      op = OP_ADD;
    end else begin
      case (roll % 3)
        0:       op = OP_DEL_KEY;
        1:       op = OP_DEL_IDX;
        default: op = OP_FIND;
      endcase
    end
    roll = $urandom_range(0, 99);
    if (sb.fill != 0 && roll < (op == OP_ADD ? 20 : 75)) begin
      key = sb.held_keys[$urandom_range(0, sb.fill - 1)];
    end else if (roll < (op == OP_ADD ? 35 : 85)) begin
      key = key_pool[$urandom_range(0, 7)];
    end else begin
      key = $urandom();
    end
    roll   = $urandom_range(0, 99);
    amount = (roll < 10) ? '0 : (roll < 20) ? '1 : AmountW'($urandom_range(0, 65535));
    if (sb.fill != 0 && $urandom_range(0, 99) < 80) begin
      slot = IndexW'($urandom_range(0, sb.fill - 1));
    end else begin
      slot = IndexW'($urandom_range(0, 63));
    end
    issue(op, key, amount, slot);
  endtask

  initial begin : stimulus
    int unsigned     add_pct;
    logic [CapW-1:0] cap;
    sb = new();
    req_if.valid       <= 1'b0;
    req_if.opcode      <= OP_ADD;
    req_if.key         <= '0;
    req_if.amount      <= '0;
    req_if.entry_index <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_capacity();

    // Directed part. The table starts empty, so every lookup misses.
    issue(OP_FIND, 32'h0000_0000, 16'h0000, 6'd0);
    issue(OP_DEL_KEY, 32'h0000_0000, 16'h0000, 6'd0);
    issue(OP_DEL_IDX, 32'h0000_0000, 16'h0000, 6'd0);
    // Extreme keys and amounts, then a duplicate of the first key.
    issue(OP_ADD, 32'h0000_0000, 16'hFFFF, 6'd0);
    issue(OP_ADD, 32'hFFFF_FFFF, 16'h0000, 6'd63);
    issue(OP_ADD, 32'h0000_0000, 16'h0005, 6'd0);
    issue(OP_ADD, 32'hA5A5_5A5A, 16'h0001, 6'd0);
    issue(OP_FIND, 32'hFFFF_FFFF, 16'h0000, 6'd0);
    // Positions at and beyond the fill level are refused.
    issue(OP_DEL_IDX, 32'h0000_0000, 16'h0000, 6'd63);
    issue(OP_DEL_IDX, 32'h0000_0000, 16'h0000, 6'd3);
    // Removing the head shifts the other entries down by one place.
    issue(OP_DEL_KEY, 32'h0000_0000, 16'h0000, 6'd0);
    issue(OP_FIND, 32'hA5A5_5A5A, 16'h0000, 6'd0);
    // A capacity equal to the fill level: the table is full, and the full status wins
    // over the duplicate status.
    configure(RegCapacity, 7'd2);
    issue(OP_ADD, 32'h0000_0007, 16'h1234, 6'd0);
    issue(OP_ADD, 32'hFFFF_FFFF, 16'h4321, 6'd0);
    // A capacity below the fill level: lookups and deletes still work, but adds are
    // refused until the count drops below the capacity.
    configure(RegCapacity, 7'd1);
    issue(OP_FIND, 32'hFFFF_FFFF, 16'h0000, 6'd0);
    issue(OP_DEL_IDX, 32'h0000_0000, 16'h0000, 6'd1);
    issue(OP_ADD, 32'h0000_0009, 16'h0003, 6'd0);
    issue(OP_DEL_KEY, 32'hFFFF_FFFF, 16'h0000, 6'd0);
    issue(OP_ADD, 32'h0000_0009, 16'h0003, 6'd0);
    // With a capacity of zero, every add is refused as full.
    configure(RegCapacity, 7'd0);
    issue(OP_ADD, 32'h0000_000B, 16'h0002, 6'd0);
    issue(OP_DEL_IDX, 32'h0000_0000, 16'h0000, 6'd0);
    // A write to a register index that does not exist changes nothing.
    configure(UnmappedAddr, 7'h7F);
    issue(OP_ADD, 32'h0000_000C, 16'h0002, 6'd0);

    // Random phases. The first one sets a capacity beyond the built depth and fills the
    // table. The later ones switch between small, full and lowered capacities and mixes.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          cap     = 7'd127;
          add_pct = 85;
        end
        1: begin
          cap     = CapacityReset;
          add_pct = 45;
        end
        2: begin
          cap     = CapW'($urandom_range(2, 8));
          add_pct = 55;
        end
        3: begin
          cap     = 7'd1;
          add_pct = 50;
        end
        4: begin
          cap     = CapW'($urandom_range(9, 63));
          add_pct = 60;
        end
        5: begin
          cap     = 7'd5;
          add_pct = 30;
        end
        default: begin
          cap     = CapacityReset;
          add_pct = 45;
        end
      endcase
      configure(RegCapacity, cap);
      if (p == PhaseCount - 1) quiet_tail = 1'b1;
      repeat (ItemsPerPhase) random_request(add_pct);
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d adds, %0d deletes by key, %0d deletes by index, %0d finds;",
             sb.op_count[OP_ADD], sb.op_count[OP_DEL_KEY], sb.op_count[OP_DEL_IDX],
             sb.op_count[OP_FIND]);
    $display("%0d capacity settings, peak fill %0d; status ok/full/dup/miss %0d/%0d/%0d/%0d.",
             capacity_settings, sb.peak_fill, sb.status_count[ST_OK],
             sb.status_count[ST_FULL], sb.status_count[ST_DUP], sb.status_count[ST_MISS]);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/uktab_pkg.sv
rtl/uktab_if.sv
rtl/uktab_ram.sv
rtl/unique_key_compacting_table.sv
test/testbench.sv
